// ----- rtl/mandelbrot_escape_time_pixel_macros.svh -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: assertion macros
// Concurrent assertion forms for the block's controller.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication
`define MBET_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbet assertion failed");

// next-cycle implication
`define MBET_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbet assertion failed");

`endif

// ----- rtl/mbet_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: package
// Fixed-point format, register indexes and controller/datapath interface.
// ----------------------------------------------------------------------------
package mbet_pkg;

   localparam int COORD_W   = 32;
   localparam int ROW_W     = 10;
   localparam int STEP_W    = 28;
   localparam int COUNT_W   = 8;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int FRAC_BITS = 28;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [PROD_W-1:0] FOUR = PROD_W'(64'sd1 <<< (FRAC_BITS + 2));

   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = 2'd2;

   typedef struct packed {
      logic load_c;
      logic init_z;
      logic mul_z;
      logic upd_z;
   } dp_cmd_type;

   typedef struct packed {
      logic escape;
   } dp_status_type;

endpackage

// ----- rtl/mandelbrot_escape_time_pixel.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: top level
// Usage:
//   req_row/req_col carry one pixel word on req_valid; the block holds
//   req_stall high while it works on a pixel and takes one pixel at a time.
//   rsp_count carries the remaining iteration count on rsp_valid; hold
//   rsp_stall high to keep the word, which then stays unchanged. csr_ready
//   is always high; csr_index/csr_data write x_min (0), y_min (1), step (2),
//   others are dropped. Write only while idle; the block does not enforce it.
// Timing:
//   A pixel runs 1..ITERATIONS iterations. col*step and row*step register
//   at acceptance, the coordinate state adds the origin, each iteration
//   takes a multiply state and an update state through three 32x32
//   multipliers, and the done state loads the output register once it is
//   free. The next pixel is taken only after that load, and may be taken
//   while a result waits in the output register.
// Reset:
//   Synchronous, active high; clears the handshakes and loads the default
//   frame origin and step.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
   import mbet_pkg::*;
#(
   parameter int ITERATIONS = 256
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ROW_W-1:0]     req_row,
   input  logic [ROW_W-1:0]     req_col,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COUNT_W-1:0]   rsp_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_data
);

   localparam int CNT_W = $clog2(ITERATIONS + 1);

   logic signed [COORD_W-1:0] x_min_ff, y_min_ff;
   logic [STEP_W-1:0]         step_ff;
   logic                      rsp_valid_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          out_free;
   logic          out_load;
   logic [CNT_W-1:0] count;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= -COORD_W'(178433490);
         y_min_ff <= COORD_W'(95446784);
         step_ff  <= STEP_W'(10354);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_MIN: x_min_ff <= csr_data;
            CSR_Y_MIN: y_min_ff <= csr_data;
            CSR_STEP:  step_ff  <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_count_ff <= COUNT_W'(count);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   mbet_ctrl #(
      .ITERATIONS (ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .out_load  (out_load),
      .count     (count),
      .cmd       (cmd),
      .status    (status)
   );

   mbet_dpath u_dpath (
      .clock  (clock),
      .cmd    (cmd),
      .row    (req_row),
      .col    (req_col),
      .x_min  (x_min_ff),
      .y_min  (y_min_ff),
      .step   (step_ff),
      .status (status)
   );

endmodule

// ----- rtl/mbet_dpath.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: datapath
// Forms c from the pixel index and iterates z = z^2 + c, each step split
// into a multiply phase and an update phase.
// ----------------------------------------------------------------------------
module mbet_dpath
   import mbet_pkg::*;
(
   input  logic                       clock,
   input  dp_cmd_type                 cmd,
   input  logic [ROW_W-1:0]           row,
   input  logic [ROW_W-1:0]           col,
   input  logic signed [COORD_W-1:0]  x_min,
   input  logic signed [COORD_W-1:0]  y_min,
   input  logic [STEP_W-1:0]          step,
   output dp_status_type              status
);

   localparam int OFS_W = ROW_W + STEP_W;
   localparam int SUM_W = OFS_W + 2;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(2147483647);
      lo = -PROD_W'(64'sd2147483648);
      if (v > hi) begin
         sat32 = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < lo) begin
         sat32 = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat32 = v[COORD_W-1:0];
      end
   endfunction

   logic [OFS_W-1:0]          colp_ff, rowp_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, x_ff, y_ff;
   logic signed [PROD_W-1:0]  xx_ff, yy_ff, xy_ff;

   logic signed [SUM_W-1:0]   cx_sum, cy_sum;
   logic signed [COORD_W-1:0] cx_in, cy_in, x_in, y_in;
   logic signed [PROD_W-1:0]  xx_prod, yy_prod, xy_prod;
   logic signed [PROD_W-1:0]  x2, y2, xy2, nx_sum, ny_sum, mag;

   assign cx_sum = SUM_W'(x_min) + signed'({2'b00, colp_ff});
   assign cy_sum = SUM_W'(y_min) + signed'({2'b00, rowp_ff});
   assign cx_in  = sat32(PROD_W'(cx_sum));
   assign cy_in  = sat32(PROD_W'(cy_sum));

   assign xx_prod = x_ff * x_ff;
   assign yy_prod = y_ff * y_ff;
   assign xy_prod = x_ff * y_ff;

   assign x2     = xx_ff >>> FRAC_BITS;
   assign y2     = yy_ff >>> FRAC_BITS;
   assign xy2    = xy_ff >>> (FRAC_BITS - 1);
   assign nx_sum = x2 - y2 + PROD_W'(cx_ff);
   assign ny_sum = xy2 + PROD_W'(cy_ff);
   assign mag    = x2 + y2;
   assign x_in   = sat32(nx_sum);
   assign y_in   = sat32(ny_sum);

   assign status.escape = (mag >= FOUR);

   always_ff @(posedge clock) begin
      if (cmd.load_c) begin
         colp_ff <= OFS_W'(col) * OFS_W'(step);
         rowp_ff <= OFS_W'(row) * OFS_W'(step);
      end
      if (cmd.init_z) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         x_ff  <= cx_in;
         y_ff  <= cy_in;
      end else if (cmd.upd_z) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (cmd.mul_z) begin
         xx_ff <= xx_prod;
         yy_ff <= yy_prod;
         xy_ff <= xy_prod;
      end
   end

endmodule

// ----- rtl/mbet_ctrl.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: controller
// Sequences coordinate setup and iteration steps, and keeps the count.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_macros.svh"

module mbet_ctrl
   import mbet_pkg::*;
#(
   parameter int ITERATIONS = 256,
   localparam int CNT_W = $clog2(ITERATIONS + 1)
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             out_free,
   output logic             out_load,
   output logic [CNT_W-1:0] count,
   output dp_cmd_type       cmd,
   input  dp_status_type    status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_MUL,
      ST_UPD,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COORD;
               cnt_in   = CNT_W'(ITERATIONS);
            end
         end
         ST_COORD: state_in = ST_MUL;
         ST_MUL:   state_in = ST_UPD;
         ST_UPD: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1) || status.escape) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign cmd.load_c  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.init_z  = (state_ff == ST_COORD);
   assign cmd.mul_z   = (state_ff == ST_MUL);
   assign cmd.upd_z   = (state_ff == ST_UPD);
   assign out_load    = (state_ff == ST_DONE) && out_free;
   assign count       = cnt_ff;

   `MBET_ASSERT_NOW(a_load_free, clock, reset, out_load, out_free)
   `MBET_ASSERT_NOW(a_cnt_live, clock, reset, (state_ff == ST_MUL || state_ff == ST_UPD), cnt_ff != '0)
   `MBET_ASSERT_NOW(a_done_cnt, clock, reset, out_load, cnt_ff < CNT_W'(ITERATIONS))
   `MBET_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall && cnt_ff == CNT_W'(ITERATIONS))

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel testbench
// Drives pixel words into the block under a series of frame origins and
// step sizes and compares every returned escape count with a fixed-point
// predictor of the z = z^2 + c iteration or, for some directed pixels, with
// a typed count. A short table of directed pixels and register writes covers
// the edges of the format, saturation, escape on the first step and points
// that never escape. Random frames follow. Both handshake sides idle at
// random, with one steady stretch and long receiver holds.
// ----------------------------------------------------------------------------
module testbench;
   import mbet_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITERATIONS      = 256;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int PAUSE_PHASE     = 2;
   localparam int TIMEOUT_NS      = 20_000_000;
   localparam int HOLD_CYCLES     = 2000;
   localparam int HOLD_AT_A       = 200;
   localparam int HOLD_AT_B       = 650;
   localparam int STEADY_FROM     = 350;
   localparam int STEADY_TO       = 500;

   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 2'd3;

   localparam logic [COORD_W-1:0] DEF_X_MIN = -32'sd178433490;
   localparam logic [COORD_W-1:0] DEF_Y_MIN = 32'd95446784;
   localparam logic [COORD_W-1:0] DEF_STEP  = 32'd10354;

   localparam logic [COUNT_W-1:0] NEVER_ESCAPED = '0;
   localparam logic [COUNT_W-1:0] FIRST_ESCAPE  = COUNT_W'(ITERATIONS - 1);

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef enum bit {DO_PIXEL, DO_WRITE} stim_kind_type;
   typedef enum bit {PREDICTED, TYPED} expect_src_type;

   typedef struct packed {
      stim_kind_type        kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [COORD_W-1:0]   data;
      logic [ROW_W-1:0]     row;
      logic [ROW_W-1:0]     col;
      expect_src_type       src;
      logic [COUNT_W-1:0]   count;
   } stim_entry_type;

   typedef struct {
      logic [ROW_W-1:0]   row;
      logic [ROW_W-1:0]   col;
      logic [COUNT_W-1:0] count;
   } pixel_count_type;

   function automatic stim_entry_type px(input int r, input int c, input expect_src_type src,
                                         input logic [COUNT_W-1:0] count);
      stim_entry_type e;
      e = '0;
      e.kind  = DO_PIXEL;
      e.row   = ROW_W'(r);
      e.col   = ROW_W'(c);
      e.src   = src;
      e.count = count;
      return e;
   endfunction

   function automatic stim_entry_type wr(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [COORD_W-1:0] data);
      stim_entry_type e;
      e = '0;
      e.kind = DO_WRITE;
      e.idx  = idx;
      e.data = data;
      return e;
   endfunction

   localparam int DIRECTED_LEN = 33;
   localparam stim_entry_type DIRECTED [DIRECTED_LEN] = '{
      px(0, 0, PREDICTED, '0),
      px(1023, 1023, PREDICTED, '0),
      px(0, 1023, PREDICTED, '0),
      px(1023, 0, PREDICTED, '0),
      px(512, 341, PREDICTED, '0),
      wr(CSR_X_MIN, 32'h7FFF_FFFF),
      wr(CSR_Y_MIN, 32'h7FFF_FFFF),
      px(0, 0, TYPED, FIRST_ESCAPE),
      px(1023, 1023, TYPED, FIRST_ESCAPE),
      wr(CSR_X_MIN, 32'h8000_0000),
      wr(CSR_Y_MIN, 32'h8000_0000),
      px(0, 0, TYPED, FIRST_ESCAPE),
      wr(CSR_STEP, 32'hFFFF_FFFF),
      px(0, 1023, TYPED, FIRST_ESCAPE),
      px(1023, 1023, TYPED, FIRST_ESCAPE),
      wr(CSR_STEP, 32'h0000_0000),
      wr(CSR_X_MIN, 32'h0000_0000),
      wr(CSR_Y_MIN, 32'h0000_0000),
      px(1023, 1023, TYPED, NEVER_ESCAPED),
      wr(CSR_NONE, 32'h1234_5678),
      px(7, 9, TYPED, NEVER_ESCAPED),
      wr(CSR_X_MIN, 32'h2000_0000),
      px(0, 0, TYPED, FIRST_ESCAPE),
      wr(CSR_X_MIN, 32'h1FFF_FFFF),
      px(0, 0, PREDICTED, '0),
      wr(CSR_X_MIN, 32'hE000_0000),
      px(3, 3, TYPED, FIRST_ESCAPE),
      wr(CSR_X_MIN, 32'hE000_0001),
      px(0, 0, PREDICTED, '0),
      wr(CSR_X_MIN, DEF_X_MIN),
      wr(CSR_Y_MIN, DEF_Y_MIN),
      wr(CSR_STEP, DEF_STEP),
      px(300, 700, PREDICTED, '0)
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [ROW_W-1:0]     req_row;
   logic [ROW_W-1:0]     req_col;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_data;

   longint          x_min_q;
   longint          y_min_q;
   longint          step_q;
   pixel_count_type pending_counts [$];
   int              errors = 0;
   int              pixels_sent = 0;
   int              counts_checked = 0;
   int              reg_writes = 0;
   int              n_first = 0;
   int              n_never = 0;

   mandelbrot_escape_time_pixel #(
      .ITERATIONS(ITERATIONS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_row(req_row),
      .req_col(req_col),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_count(rsp_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit steady_now();
      return pixels_sent >= STEADY_FROM && pixels_sent < STEADY_TO;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   function automatic logic [COUNT_W-1:0] escape_count(input logic [ROW_W-1:0] r,
                                                       input logic [ROW_W-1:0] c);
      longint      cx, cy, zx, zy, sq_x, sq_y;
      int unsigned left;
      cx = clamp32(x_min_q + longint'(c) * step_q);
      cy = clamp32(y_min_q + longint'(r) * step_q);
      zx = cx;
      zy = cy;
      left = ITERATIONS;
      do begin
         sq_x = (zx * zx) >>> FRAC_BITS;
         sq_y = (zy * zy) >>> FRAC_BITS;
         zy = clamp32(((zx * zy) >>> (FRAC_BITS - 1)) + cy);
         zx = clamp32(sq_x - sq_y + cx);
         left = left - 1;
      end while (left > 0 && (sq_x + sq_y) < FOUR);
      return COUNT_W'(left);
   endfunction

   task automatic send_pixel(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] c,
                             input expect_src_type src, input logic [COUNT_W-1:0] want);
      pixel_count_type item;
      if (!steady_now() && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 17);
      end
      req_valid <= 1'b1;
      req_row   <= r;
      req_col   <= c;
      do @(posedge clock); while (req_stall);
      item.row   = r;
      item.col   = c;
      item.count = (src == TYPED) ? want : escape_count(r, c);
      pending_counts.push_back(item);
      pixels_sent++;
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_X_MIN: x_min_q = longint'($signed(data));
         CSR_Y_MIN: y_min_q = longint'($signed(data));
         CSR_STEP:  step_q  = longint'(data[STEP_W-1:0]);
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // hold results for long stretches so the block backs up into its input
   initial begin
      int holds;
      rsp_stall = 1'b0;
      holds = 0;
      forever begin
         @(posedge clock);
         if ((holds == 0 && pixels_sent >= HOLD_AT_A) ||
             (holds == 1 && pixels_sent >= HOLD_AT_B)) begin
            holds++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !steady_now() && ($urandom_range(0, 99) < 17);
         end
      end
   end

   always @(posedge clock) begin : check_counts
      pixel_count_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected word, expected none, actual count %0d",
                     $time, rsp_count);
         end else begin
            head = pending_counts.pop_front();
            counts_checked++;
            if (rsp_count !== head.count) begin
               errors++;
               $display("%0t ns: pixel (%0d,%0d) count expected %0d, actual %0d",
                        $time, head.row, head.col, head.count, rsp_count);
            end
            if (head.count == FIRST_ESCAPE) n_first++;
            if (head.count == NEVER_ESCAPED) n_never++;
         end
      end
   end

   initial begin
      #TIMEOUT_NS;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      stim_entry_type     e;
      logic [COORD_W-1:0] xm, ym, st;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_row   = '0;
      req_col   = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      x_min_q   = longint'($signed(DEF_X_MIN));
      y_min_q   = longint'($signed(DEF_Y_MIN));
      step_q    = longint'(DEF_STEP[STEP_W-1:0]);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_LEN; i++) begin
         e = DIRECTED[i];
         if (e.kind == DO_WRITE) begin
            drain_pixels();
            write_reg(e.idx, e.data);
         end else begin
            send_pixel(e.row, e.col, e.src, e.count);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin
               xm = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
               ym = $urandom_range(0, 32'h2666_6666) - 32'h1333_3333;
               st = $urandom_range(1, 1024);
            end
            1: begin
               xm = $urandom_range(0, 32'h0800_0000) - 32'h2800_0000;
               ym = $urandom_range(0, 32'h0800_0000) - 32'h1800_0000;
               st = $urandom_range(262144, 786432);
            end
            2: begin
               xm = $urandom_range(0, 32'h1000_0000) - 32'h3000_0000;
               ym = $urandom_range(0, 32'h1000_0000) - 32'h3000_0000;
               st = $urandom_range(786432, 32'h0040_0000);
            end
            default: begin
               xm = $urandom;
               ym = $urandom;
               st = $urandom;
            end
         endcase
         drain_pixels();
         write_reg(CSR_X_MIN, xm);
         write_reg(CSR_Y_MIN, ym);
         write_reg(CSR_STEP, st);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            send_pixel(ROW_W'($urandom_range(0, 1023)), ROW_W'($urandom_range(0, 1023)),
                       PREDICTED, '0);
            if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) drain_pixels();
         end
      end

      drain_pixels();
      repeat (2 * ITERATIONS + 8) @(posedge clock);
      errors += pending_counts.size();

      $display("summary: %0d pixels sent, %0d counts checked, %0d register writes",
               pixels_sent, counts_checked, reg_writes);
      $display("summary: %0d escaped on the first step, %0d never escaped",
               n_first, n_never);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mbet_pkg.sv
rtl/mbet_dpath.sv
rtl/mbet_ctrl.sv
rtl/mandelbrot_escape_time_pixel.sv
sim/testbench.sv
